// ----- sv/srcp_pkg.sv -----
// ----------------------------------------------------------------------------
// SMTP reply code parser - shared definitions
// Widths, ASCII codes, parser positions and result status codes.
// ----------------------------------------------------------------------------
package srcp_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 10;
    localparam int STATUS_W = 2;
    localparam int POS_W = 3;

    localparam int DEFAULT_MAX_REPLY_BYTES = 1024;

    localparam logic [CODE_W-1:0] EXPECTED_CODE_RESET = 10'd220;

    localparam logic [BYTE_W-1:0] ASCII_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] ASCII_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] ASCII_DASH = 8'h2D;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    // line_position: 0..3 digits taken, then done or dead
    localparam logic [POS_W-1:0] POS_CODE_END = 3'd3;
    localparam logic [POS_W-1:0] POS_DONE = 3'd4;
    localparam logic [POS_W-1:0] POS_DEAD = 3'd7;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_DIFFER   = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [CODE_W-1:0]   reply_code;
    } result_t;

endpackage

// ----- sv/srcp_parser.sv -----
// ----------------------------------------------------------------------------
// SMTP reply code parser - per-byte parse stage
// Holds the line/code tracking state, consumes one byte per step and
// produces at most one result for that byte.
// ----------------------------------------------------------------------------
module srcp_parser #(
    parameter int MAX_REPLY_BYTES = srcp_pkg::DEFAULT_MAX_REPLY_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_i,
    input  logic [srcp_pkg::BYTE_W-1:0]   byte_i,
    input  logic [srcp_pkg::CODE_W-1:0]   expected_code_i,
    output logic                          res_valid_o,
    output srcp_pkg::result_t             res_o
);
    import srcp_pkg::*;

    localparam int CNT_W = $clog2(MAX_REPLY_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_REPLY_BYTES - 1);

    logic              at_line_start_reg, at_line_start_next;
    logic [POS_W-1:0]  line_position_reg, line_position_next;
    logic [CODE_W-1:0] code_acc_reg, code_acc_next;
    logic              final_seen_reg, final_seen_next;
    logic              prev_cr_reg, prev_cr_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;

    logic              is_lf;
    logic              is_cr;
    logic              is_digit;
    logic [POS_W-1:0]  pos_base;
    logic [CODE_W-1:0] acc_base;
    logic [CODE_W-1:0] digit;

    always_comb begin
        is_lf    = (byte_i == ASCII_LF);
        is_cr    = (byte_i == ASCII_CR);
        is_digit = (byte_i >= ASCII_ZERO) && (byte_i <= ASCII_NINE);
        digit    = CODE_W'(byte_i - ASCII_ZERO);
        pos_base = at_line_start_reg ? '0 : line_position_reg;
        acc_base = at_line_start_reg ? '0 : code_acc_reg;

        at_line_start_next = at_line_start_reg;
        line_position_next = line_position_reg;
        code_acc_next      = code_acc_reg;
        final_seen_next    = final_seen_reg;
        prev_cr_next       = prev_cr_reg;
        byte_count_next    = byte_count_reg;
        res_valid_o        = 1'b0;
        res_o.status       = STATUS_TOO_LONG;
        res_o.reply_code   = '0;

        if (step_i) begin
            if (byte_count_reg == CNT_LAST) begin
                // limit reached: wins over a completing CR LF
                res_valid_o = 1'b1;
            end else if (final_seen_reg && prev_cr_reg && is_lf) begin
                res_valid_o      = 1'b1;
                res_o.status     = (code_acc_reg == expected_code_i) ?
                                   STATUS_MATCH : STATUS_DIFFER;
                res_o.reply_code = code_acc_reg;
            end else begin
                byte_count_next    = byte_count_reg + 1'b1;
                at_line_start_next = is_lf;
                prev_cr_next       = is_cr;
                if (!final_seen_reg) begin
                    line_position_next = pos_base;
                    code_acc_next      = acc_base;
                    if (pos_base < POS_CODE_END) begin
                        if (is_digit) begin
                            code_acc_next = CODE_W'((acc_base << 3) + (acc_base << 1) + digit);
                            line_position_next = pos_base + 1'b1;
                        end else begin
                            line_position_next = POS_DEAD;
                        end
                    end else if (pos_base == POS_CODE_END) begin
                        if (byte_i != ASCII_DASH) begin
                            final_seen_next = 1'b1;
                        end
                        line_position_next = POS_DONE;
                    end
                end
            end

            if (res_valid_o) begin
                at_line_start_next = 1'b1;
                line_position_next = '0;
                code_acc_next      = '0;
                final_seen_next    = 1'b0;
                prev_cr_next       = 1'b0;
                byte_count_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_line_start_reg <= 1'b1;
            line_position_reg <= '0;
            code_acc_reg      <= '0;
            final_seen_reg    <= 1'b0;
            prev_cr_reg       <= 1'b0;
            byte_count_reg    <= '0;
        end else begin
            at_line_start_reg <= at_line_start_next;
            line_position_reg <= line_position_next;
            code_acc_reg      <= code_acc_next;
            final_seen_reg    <= final_seen_next;
            prev_cr_reg       <= prev_cr_next;
            byte_count_reg    <= byte_count_next;
        end
    end

endmodule

// ----- sv/smtp_reply_code_parser_top.sv -----
// ----------------------------------------------------------------------------
// SMTP reply code parser - top level
// Input register, per-byte parse stage and result register.
// ----------------------------------------------------------------------------
// Takes one received reply byte per transfer and sustains one byte per clock
// while back-pressure on m_ready does not stall it. A byte is parsed straight
// out of the input register, and any result it causes is captured in the
// result register, which drives the m_ side.
// The parse stage advances whenever the result register is empty or being
// drained, so back-pressure on m_ready is the only thing that slows input.
// A result is emitted on the LF of the first CR LF after the final reply
// line's code; status 0 means the code equals expected_code, 1 that it differs,
// 2 that MAX_REPLY_BYTES bytes arrived first (reply_code is then 0).
// expected_code resets to 220 and may only be written while idle.
module smtp_reply_code_parser_top #(
    parameter int MAX_REPLY_BYTES = srcp_pkg::DEFAULT_MAX_REPLY_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [srcp_pkg::CODE_W-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [srcp_pkg::BYTE_W-1:0]     s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [srcp_pkg::STATUS_W-1:0]   m_status,
    output logic [srcp_pkg::CODE_W-1:0]     m_reply_code
);
    import srcp_pkg::*;

    logic [CODE_W-1:0] expected_code_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_result_reg;

    logic              out_free;
    logic              step;
    logic              res_valid;
    result_t           res;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_code_reg <= EXPECTED_CODE_RESET;
        end else if (cfg_wr_en) begin
            expected_code_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    srcp_parser #(
        .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_i          (step),
        .byte_i          (in_byte_reg),
        .expected_code_i (expected_code_reg),
        .res_valid_o     (res_valid),
        .res_o           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            out_result_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_result_reg.status;
    assign m_reply_code = out_result_reg.reply_code;

endmodule
